/* hdl/svfg_pkg.sv */
`timescale 1ns / 1ps
// Package for the symmetry vector field generator: register indexes, field
// modes, fixed-point constants and the CORDIC arctangent table. No dependencies.
package svfg_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int ATAN_ENTRIES   = 24;

	// Configuration register indexes.
	localparam logic [1:0] REG_FIELD_MODE = 2'd0;
	localparam logic [1:0] REG_VECTOR_X   = 2'd1;
	localparam logic [1:0] REG_VECTOR_Y   = 2'd2;
	localparam logic [1:0] REG_VECTOR_Z   = 2'd3;

	// Field modes.
	localparam logic [2:0] MODE_ROT_Z   = 3'd0;
	localparam logic [2:0] MODE_ROT_X   = 3'd1;
	localparam logic [2:0] MODE_ROT_Y   = 3'd2;
	localparam logic [2:0] MODE_TRANS_X = 3'd3;
	localparam logic [2:0] MODE_TRANS_Y = 3'd4;
	localparam logic [2:0] MODE_TRANS_Z = 3'd5;
	localparam logic [2:0] MODE_CUSTOM  = 3'd6;
	localparam logic [2:0] MODE_OMEGA   = 3'd7;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [47:0] ONE_Q16     = 48'sd65536;
	localparam logic signed [35:0] COORD_MAX   = 36'sd4294967295;
	localparam logic signed [49:0] OUT_MAX     = 50'sd140737488355327;
	localparam logic signed [49:0] OUT_MIN     = -50'sd140737488355328;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic signed [33:0] atan_turns(input int i);
		logic signed [33:0] v;
		begin
			case (i)
				0: v = 34'sd536870912;
				1: v = 34'sd316933406;
				2: v = 34'sd167458907;
				3: v = 34'sd85004756;
				4: v = 34'sd42667331;
				5: v = 34'sd21354465;
				6: v = 34'sd10679838;
				7: v = 34'sd5340245;
				8: v = 34'sd2670163;
				9: v = 34'sd1335087;
				10: v = 34'sd667544;
				11: v = 34'sd333772;
				12: v = 34'sd166886;
				13: v = 34'sd83443;
				14: v = 34'sd41722;
				15: v = 34'sd20861;
				16: v = 34'sd10430;
				17: v = 34'sd5215;
				18: v = 34'sd2608;
				19: v = 34'sd1304;
				20: v = 34'sd652;
				21: v = 34'sd326;
				22: v = 34'sd163;
				23: v = 34'sd81;
				default: v = 34'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

/* hdl/symmetry_vector_field_gen.sv */
`timescale 1ns / 1ps
// Symmetry vector field generator: spherical grid point to Cartesian, then a
// field vector chosen by mode. Depends on svfg_pkg.
//
// Usage:
//   The slave stream takes one grid point per request: s_tdata holds radius,
//   polar angle and azimuth. The master stream returns one field vector per
//   request in m_tdata. Configuration (mode, custom vector or omega) is written
//   through cfg_we/cfg_index/cfg_data while no request is in flight.
//   The pipeline is one setup stage, one stage per CORDIC iteration for the
//   two angles in parallel, then the factor multiply, the coordinate
//   multiply, the omega products and the output select with saturation.
//   Throughput is one request per cycle while m_tready is high; each stage
//   holds one request and loads whenever it is empty or the stage after it
//   moves, so bubbles are squeezed out and input is still taken while a
//   result waits downstream. When the receiver stalls, results back up
//   stage by stage and s_tready falls only when every stage is full; nothing
//   is dropped or repeated.
//   Reset clears all valid bits and the configuration registers (mode rot_z,
//   vector zero).
module symmetry_vector_field_gen
	import svfg_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // radius[31:0], polar_angle[47:32], azimuth[63:48]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // field_x[47:0], field_y[95:48], field_z[143:96]
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int N  = (ANGLE_BITS > ATAN_ENTRIES) ? ATAN_ENTRIES : ANGLE_BITS;
	localparam int NS = N + 5;
	localparam int SM = N + 1;   // factor multiply stage
	localparam int SC = N + 2;   // coordinate stage
	localparam int SP = N + 3;   // omega product stage
	localparam int SO = N + 4;   // output stage

	logic [2:0]         mode_q;
	logic signed [31:0] vx_q, vy_q, vz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ROT_Z;
			vx_q   <= '0;
			vy_q   <= '0;
			vz_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIELD_MODE: mode_q <= cfg_data[2:0];
				REG_VECTOR_X:   vx_q   <= cfg_data;
				REG_VECTOR_Y:   vy_q   <= cfg_data;
				REG_VECTOR_Z:   vz_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits and the ready chain; a stage loads when empty or draining.
	logic [NS-1:0] v_q;
	logic [NS:0]   rdy;

	always_comb begin
		rdy[NS] = m_tready;
		for (int k = NS - 1; k >= 0; k--)
			rdy[k] = !v_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k])
					v_q[k] <= (k == 0) ? s_tvalid : v_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = v_q[NS-1];

	// CORDIC pipeline: index 0 is the setup stage, index i+1 follows iteration i.
	logic signed [33:0] tx_s1 [0:N];
	logic signed [33:0] ty_s1 [0:N];
	logic signed [33:0] tz_s1 [0:N];
	logic signed [33:0] px_s1 [0:N];
	logic signed [33:0] py_s1 [0:N];
	logic signed [33:0] pz_s1 [0:N];
	logic               tf_s1 [0:N];
	logic               pf_s1 [0:N];
	logic [31:0]        r_s1  [0:N];

	logic [31:0] ta, pa;
	logic        tflip, pflip;

	always_comb begin
		ta    = {s_tdata[47:32], 16'b0};
		pa    = {s_tdata[63:48], 16'b0};
		// Left half-plane angles are turned by half a turn.
		tflip = ta[31] ^ ta[30];
		pflip = pa[31] ^ pa[30];
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			tx_s1[0] <= CORDIC_GAIN;
			ty_s1[0] <= '0;
			tz_s1[0] <= 34'(signed'({ta[31] ^ tflip, ta[30:0]}));
			px_s1[0] <= CORDIC_GAIN;
			py_s1[0] <= '0;
			pz_s1[0] <= 34'(signed'({pa[31] ^ pflip, pa[30:0]}));
			tf_s1[0] <= tflip;
			pf_s1[0] <= pflip;
			r_s1[0]  <= s_tdata[31:0];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (rdy[i+1]) begin
				if (!tz_s1[i][33]) begin
					tx_s1[i+1] <= tx_s1[i] - (ty_s1[i] >>> i);
					ty_s1[i+1] <= ty_s1[i] + (tx_s1[i] >>> i);
					tz_s1[i+1] <= tz_s1[i] - atan_turns(i);
				end else begin
					tx_s1[i+1] <= tx_s1[i] + (ty_s1[i] >>> i);
					ty_s1[i+1] <= ty_s1[i] - (tx_s1[i] >>> i);
					tz_s1[i+1] <= tz_s1[i] + atan_turns(i);
				end
				if (!pz_s1[i][33]) begin
					px_s1[i+1] <= px_s1[i] - (py_s1[i] >>> i);
					py_s1[i+1] <= py_s1[i] + (px_s1[i] >>> i);
					pz_s1[i+1] <= pz_s1[i] - atan_turns(i);
				end else begin
					px_s1[i+1] <= px_s1[i] + (py_s1[i] >>> i);
					py_s1[i+1] <= py_s1[i] - (px_s1[i] >>> i);
					pz_s1[i+1] <= pz_s1[i] + atan_turns(i);
				end
				tf_s1[i+1] <= tf_s1[i];
				pf_s1[i+1] <= pf_s1[i];
				r_s1[i+1]  <= r_s1[i];
			end
		end
	end

	// Factor stage: sin(theta)cos(phi), sin(theta)sin(phi) and cos(theta) in Q2.30.
	logic signed [33:0] st_w, ct_w, sp_w, cp_w;
	logic signed [63:0] fx_m, fy_m;
	logic signed [32:0] fx_s2, fy_s2, ct_s2;
	logic [31:0]        r_s2;

	always_comb begin
		st_w = tf_s1[N] ? -ty_s1[N] : ty_s1[N];
		ct_w = tf_s1[N] ? -tx_s1[N] : tx_s1[N];
		sp_w = pf_s1[N] ? -py_s1[N] : py_s1[N];
		cp_w = pf_s1[N] ? -px_s1[N] : px_s1[N];
		fx_m = 64'(signed'(st_w[31:0])) * 64'(signed'(cp_w[31:0])) + 64'sd536870912;
		fy_m = 64'(signed'(st_w[31:0])) * 64'(signed'(sp_w[31:0])) + 64'sd536870912;
	end

	always_ff @(posedge clk) begin
		if (rdy[SM]) begin
			fx_s2 <= fx_m[62:30];
			fy_s2 <= fy_m[62:30];
			ct_s2 <= 33'(signed'(ct_w[31:0]));
			r_s2  <= r_s1[N];
		end
	end

	// Coordinate stage: radius times factor, rounded to Q16 and clamped.
	logic signed [65:0] cx_m, cy_m, cz_m;
	logic signed [32:0] x_s3, y_s3, z_s3;

	function automatic logic signed [32:0] clamp_coord(input logic signed [65:0] p);
		logic signed [35:0] s;
		begin
			s = p[65:30];
			if (s > COORD_MAX)
				return 33'(COORD_MAX);
			else if (s < -COORD_MAX)
				return 33'(-COORD_MAX);
			else
				return s[32:0];
		end
	endfunction

	always_comb begin
		cx_m = 66'(signed'({1'b0, r_s2})) * 66'(fx_s2) + 66'sd536870912;
		cy_m = 66'(signed'({1'b0, r_s2})) * 66'(fy_s2) + 66'sd536870912;
		cz_m = 66'(signed'({1'b0, r_s2})) * 66'(ct_s2) + 66'sd536870912;
	end

	always_ff @(posedge clk) begin
		if (rdy[SC]) begin
			x_s3 <= clamp_coord(cx_m);
			y_s3 <= clamp_coord(cy_m);
			z_s3 <= clamp_coord(cz_m);
		end
	end

	// Omega products, each rounded to Q16.
	logic signed [64:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
	logic signed [48:0] p_yz_s4, p_zy_s4, p_zx_s4, p_xz_s4, p_xy_s4, p_yx_s4;
	logic signed [32:0] x_s4, y_s4, z_s4;

	always_comb begin
		m_yz = 65'(vy_q) * 65'(z_s3) + 65'sd32768;
		m_zy = 65'(vz_q) * 65'(y_s3) + 65'sd32768;
		m_zx = 65'(vz_q) * 65'(x_s3) + 65'sd32768;
		m_xz = 65'(vx_q) * 65'(z_s3) + 65'sd32768;
		m_xy = 65'(vx_q) * 65'(y_s3) + 65'sd32768;
		m_yx = 65'(vy_q) * 65'(x_s3) + 65'sd32768;
	end

	always_ff @(posedge clk) begin
		if (rdy[SP]) begin
			p_yz_s4 <= m_yz[64:16];
			p_zy_s4 <= m_zy[64:16];
			p_zx_s4 <= m_zx[64:16];
			p_xz_s4 <= m_xz[64:16];
			p_xy_s4 <= m_xy[64:16];
			p_yx_s4 <= m_yx[64:16];
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			z_s4    <= z_s3;
		end
	end

	// Output stage: mode select, with 48-bit saturation of the omega products.
	function automatic logic signed [47:0] sat48(input logic signed [49:0] d);
		begin
			if (d > OUT_MAX)
				return OUT_MAX[47:0];
			else if (d < OUT_MIN)
				return OUT_MIN[47:0];
			else
				return d[47:0];
		end
	endfunction

	logic signed [47:0] xw, yw, zw, fx_w, fy_w, fz_w;
	logic signed [47:0] fx_s5, fy_s5, fz_s5;

	always_comb begin
		xw   = 48'(x_s4);
		yw   = 48'(y_s4);
		zw   = 48'(z_s4);
		fx_w = '0;
		fy_w = '0;
		fz_w = '0;
		unique case (mode_q)
			MODE_ROT_Z: begin
				fx_w = -yw;
				fy_w = xw;
			end
			MODE_ROT_X: begin
				fy_w = -zw;
				fz_w = yw;
			end
			MODE_ROT_Y: begin
				fx_w = zw;
				fz_w = -xw;
			end
			MODE_TRANS_X: fx_w = ONE_Q16;
			MODE_TRANS_Y: fy_w = ONE_Q16;
			MODE_TRANS_Z: fz_w = ONE_Q16;
			MODE_CUSTOM: begin
				fx_w = 48'(vx_q);
				fy_w = 48'(vy_q);
				fz_w = 48'(vz_q);
			end
			MODE_OMEGA: begin
				fx_w = sat48(50'(p_yz_s4) - 50'(p_zy_s4));
				fy_w = sat48(50'(p_zx_s4) - 50'(p_xz_s4));
				fz_w = sat48(50'(p_xy_s4) - 50'(p_yx_s4));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[SO]) begin
			fx_s5 <= fx_w;
			fy_s5 <= fy_w;
			fz_s5 <= fz_w;
		end
	end

	assign m_tdata = {fz_s5, fy_s5, fx_s5};

endmodule
